[sv/rmss_pkg.sv]
// Shared types, step codes and helpers for the resistive matrix scan sequencer.
package rmss_pkg;

	// Numeric step codes as seen on the scan_step field.
	localparam logic [3:0] STEP_RELEASE   = 4'd0;
	localparam logic [3:0] STEP_DRIVE     = 4'd1;
	localparam logic [3:0] STEP_SETTLE    = 4'd2;
	localparam logic [3:0] STEP_START     = 4'd3;
	localparam logic [3:0] STEP_WAIT      = 4'd4;
	localparam logic [3:0] STEP_SAVE      = 4'd5;
	localparam logic [3:0] STEP_NEXT_COL  = 4'd6;
	localparam logic [3:0] STEP_NEXT_ROW  = 4'd7;
	localparam logic [3:0] STEP_WAIT_HOST = 4'd8;

	// Fixed widths of the payload fields.
	localparam int unsigned ADC_W     = 12;
	localparam int unsigned INDEX_W   = 3;
	localparam int unsigned SLOT_W    = 6;
	localparam int unsigned SETTLE_W  = 8;

	// Scan sequencer states, one-hot.
	typedef enum logic [8:0] {
		ST_RELEASE   = 9'b0_0000_0001,
		ST_DRIVE     = 9'b0_0000_0010,
		ST_SETTLE    = 9'b0_0000_0100,
		ST_START     = 9'b0_0000_1000,
		ST_WAIT      = 9'b0_0001_0000,
		ST_SAVE      = 9'b0_0010_0000,
		ST_NEXT_COL  = 9'b0_0100_0000,
		ST_NEXT_ROW  = 9'b0_1000_0000,
		ST_WAIT_HOST = 9'b1_0000_0000
	} scan_state_t;

	// One scan tick.
	typedef struct packed {
		logic              conversion_done;
		logic [ADC_W-1:0]  adc_sample;
		logic              frame_sent;
	} tick_t;

	// One result per tick.
	typedef struct packed {
		logic               drive_active;
		logic [INDEX_W-1:0] drive_row;
		logic [INDEX_W-1:0] adc_channel;
		logic               adc_start;
		logic               sample_valid;
		logic [ADC_W-1:0]   sample_value;
		logic [SLOT_W-1:0]  sample_slot;
		logic               frame_last;
		logic               frame_ready;
		logic [3:0]         scan_step;
	} result_t;

	// Maps a one-hot state to its numeric step code.
	function automatic logic [3:0] step_code(scan_state_t st);
		logic [3:0] code;
		unique case (st)
			ST_RELEASE:   code = STEP_RELEASE;
			ST_DRIVE:     code = STEP_DRIVE;
			ST_SETTLE:    code = STEP_SETTLE;
			ST_START:     code = STEP_START;
			ST_WAIT:      code = STEP_WAIT;
			ST_SAVE:      code = STEP_SAVE;
			ST_NEXT_COL:  code = STEP_NEXT_COL;
			ST_NEXT_ROW:  code = STEP_NEXT_ROW;
			ST_WAIT_HOST: code = STEP_WAIT_HOST;
			default:      code = STEP_RELEASE;
		endcase
		return code;
	endfunction

endpackage

[sv/rmss_ifs.sv]
// Valid/ready channel interfaces for ticks, results and the settle register.

interface rmss_tick_if import rmss_pkg::*; ();
	logic  valid;
	logic  ready;
	tick_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmss_result_if import rmss_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rmss_cfg_if import rmss_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SETTLE_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/resistive_matrix_scan_sequencer_unit.sv]
// Top level of the resistive matrix scan sequencer: step machine and result register.
//
//  channel | modport | beat carries
//  --------+---------+-------------------------------------------------
//  cfg     | sink    | settle_ticks, 8 bits, always accepted
//  tick    | sink    | conversion_done, adc_sample, frame_sent
//  result  | source  | drives, converter select, sample record, status
//
// Each tick beat passes through the step logic, which runs between the state
// registers and the result register; one beat is accepted per cycle unless the result stalls.
// A result appears in the cycle after its tick and holds until taken; a tick
// is accepted while the result register is empty or being drained.
// Reset clears the step state, indices, flags and the result valid; the
// settle register resets to one.
module resistive_matrix_scan_sequencer_unit import rmss_pkg::*; #(
	parameter int unsigned ROWS        = 8,
	parameter int unsigned COLS        = 8,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	rmss_cfg_if.sink        cfg,
	rmss_tick_if.sink       tick,
	rmss_result_if.source   result
);

	localparam int unsigned RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CW     = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int unsigned HELD_W = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
	localparam int unsigned PROD_W = RW + CW + SLOT_W;
	localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

	scan_state_t         state_q, state_d;
	logic [RW-1:0]       row_q, row_d;
	logic [CW-1:0]       col_q, col_d;
	logic                driven_q, driven_d;
	logic [RW-1:0]       drow_q, drow_d;
	logic                rdy_q, rdy_d;
	logic [SETTLE_W-1:0] settle_cnt_q, settle_cnt_d;
	logic [HELD_W-1:0]   held_q, held_d;
	logic [SETTLE_W-1:0] settle_ticks_q;
	logic [SETTLE_W-1:0] limit;
	logic                start, valid, last;
	logic [PROD_W-1:0]   slot_full;
	logic [PROD_W-1:0]   drow_ext;
	logic [PROD_W-1:0]   col_ext;
	logic [PROD_W-1:0]   chan_ext;
	logic                out_valid_q;
	result_t             out_q;
	logic                accept;
	result_t             res;

	// Settle register write port.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_ticks_q <= SETTLE_W'(1);
		end else if (cfg.valid) begin
			settle_ticks_q <= cfg.data;
		end
	end

	// A tick is taken whenever the result register can move on.
	assign tick.ready = !out_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;

	// A zero settle setting behaves like one.
	assign limit = (settle_ticks_q == '0) ? SETTLE_W'(1) : settle_ticks_q;

	// Step logic for one tick.
	always_comb begin
		state_d      = state_q;
		row_d        = row_q;
		col_d        = col_q;
		driven_d     = driven_q;
		drow_d       = drow_q;
		settle_cnt_d = settle_cnt_q;
		held_d       = held_q;
		start        = 1'b0;
		valid        = 1'b0;
		last         = 1'b0;
		// The host's clear lands before the step is evaluated.
		rdy_d        = tick.data.frame_sent ? 1'b0 : rdy_q;

		unique case (state_q)
			ST_RELEASE: begin
				driven_d = 1'b0;
				state_d  = ST_DRIVE;
			end
			ST_DRIVE: begin
				driven_d     = 1'b1;
				drow_d       = row_q;
				settle_cnt_d = '0;
				state_d      = ST_SETTLE;
			end
			ST_SETTLE: begin
				settle_cnt_d = settle_cnt_q + SETTLE_W'(1);
				if (settle_cnt_d >= limit) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				start   = 1'b1;
				held_d  = '0;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (tick.data.conversion_done) begin
					held_d  = tick.data.adc_sample[HELD_W-1:0];
					state_d = ST_SAVE;
				end
			end
			ST_SAVE: begin
				valid   = 1'b1;
				last    = (row_q == ROW_LAST) && (col_q == COL_LAST);
				state_d = ST_NEXT_COL;
			end
			ST_NEXT_COL: begin
				if (col_q == COL_LAST) begin
					col_d   = '0;
					state_d = ST_NEXT_ROW;
				end else begin
					col_d        = col_q + CW'(1);
					settle_cnt_d = '0;
					state_d      = ST_SETTLE;
				end
			end
			ST_NEXT_ROW: begin
				if (row_q == ROW_LAST) begin
					row_d   = '0;
					rdy_d   = 1'b1;
					state_d = ST_WAIT_HOST;
				end else begin
					row_d   = row_q + RW'(1);
					state_d = ST_RELEASE;
				end
			end
			ST_WAIT_HOST: begin
				if (!rdy_d) begin
					state_d = ST_RELEASE;
				end
			end
			default: begin
				state_d = ST_RELEASE;
			end
		endcase
	end

	// Slot number is row times columns plus column, kept to the field width.
	assign col_ext   = PROD_W'(col_q);
	assign slot_full = PROD_W'(row_q) * PROD_W'(COLS) + col_ext;
	assign drow_ext  = PROD_W'(drow_d);
	assign chan_ext  = PROD_W'(col_d);

	// Result fields from the updated state; sample value and slot come from the current state.
	always_comb begin
		res.drive_active = driven_d;
		res.drive_row    = drow_ext[INDEX_W-1:0];
		res.adc_channel  = chan_ext[INDEX_W-1:0];
		res.adc_start    = start;
		res.sample_valid = valid;
		res.sample_value = valid ? ADC_W'(held_q) : '0;
		res.sample_slot  = valid ? slot_full[SLOT_W-1:0] : '0;
		res.frame_last   = last;
		res.frame_ready  = rdy_d;
		res.scan_step    = step_code(state_d);
	end

	// Step state registers, updated once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RELEASE;
			row_q        <= '0;
			col_q        <= '0;
			driven_q     <= 1'b0;
			drow_q       <= '0;
			rdy_q        <= 1'b0;
			settle_cnt_q <= '0;
			held_q       <= '0;
		end else if (accept) begin
			state_q      <= state_d;
			row_q        <= row_d;
			col_q        <= col_d;
			driven_q     <= driven_d;
			drow_q       <= drow_d;
			rdy_q        <= rdy_d;
			settle_cnt_q <= settle_cnt_d;
			held_q       <= held_d;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick.ready) begin
			out_valid_q <= tick.valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule
